### design/dktr_pkg.sv
package dktr_pkg;

  // Defaults for the top-level parameters.
  localparam int CAPACITY_DEF   = 64;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  // Fixed widths of the channel fields.
  localparam int KIND_BITS  = 3;
  localparam int FIELD_BITS = 32;
  localparam int DRAW_BITS  = 16;
  localparam int TOTAL_BITS = 7;

  typedef logic [KIND_BITS-1:0] kind_t;

  localparam kind_t KIND_PUT      = 3'd0;
  localparam kind_t KIND_GET      = 3'd1;
  localparam kind_t KIND_CONTAINS = 3'd2;
  localparam kind_t KIND_REMOVE   = 3'd3;
  localparam kind_t KIND_PICK     = 3'd4;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

endpackage

### design/dktr_req_if.sv
interface dktr_req_if import dktr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  kind_t                 kind;
  logic [FIELD_BITS-1:0] req_key;
  logic [FIELD_BITS-1:0] req_value;
  logic [DRAW_BITS-1:0]  random_draw;

  modport source (output valid, kind, req_key, req_value, random_draw, input ready);
  modport sink   (input valid, kind, req_key, req_value, random_draw, output ready);
endinterface

### design/dktr_rsp_if.sv
interface dktr_rsp_if import dktr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  status_e               status;
  logic                  present;
  logic [FIELD_BITS-1:0] out_key;
  logic [FIELD_BITS-1:0] out_value;
  logic [TOTAL_BITS-1:0] entry_total;

  modport source (output valid, status, present, out_key, out_value, entry_total,
                  input ready);
  modport sink   (input valid, status, present, out_key, out_value, entry_total,
                  output ready);
endinterface

### design/dktr_ram.sv
module dktr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### design/dktr_mod.sv
module dktr_mod import dktr_pkg::*; #(
  parameter int CW = 7
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DRAW_BITS-1:0] dividend_i,
  input  logic [CW-1:0]        divisor_i,
  output logic                 done_o,
  output logic [CW-1:0]        rem_o
);

  localparam int SW = $clog2(DRAW_BITS);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [SW-1:0]        cnt_q, cnt_d;
  logic [CW-1:0]        rem_q, rem_d;
  logic [CW-1:0]        div_q, div_d;
  logic [DRAW_BITS-1:0] num_q, num_d;
  logic [CW:0]          trial;
  logic [CW:0]          diff;

  // Restoring division, one dividend bit per cycle; only the remainder is kept.
  assign trial = {rem_q, num_q[DRAW_BITS-1]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    div_d  = div_q;
    num_d  = num_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      div_d  = divisor_i;
      num_d  = dividend_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = diff[CW-1:0];
      end else begin
        rem_d = trial[CW-1:0];
      end
      num_d = {num_q[DRAW_BITS-2:0], 1'b0};
      cnt_d = cnt_q + SW'(1);
      if (cnt_q == SW'(DRAW_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    num_q <= num_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

### design/dense_keyed_table_with_random_pick_top.sv
// Channel | Dir | Modport | Payload
// req_i   | in  | sink    | kind, req_key, req_value, random_draw
// rsp_o   | out | source  | status, present, out_key, out_value, entry_total
//
// One request at a time. Put, get, contains and remove search the keys, reading
// one slot per cycle from the pair RAM; a remove that finds its key then reads the
// last pair and writes it into the freed slot. A random pick runs the remainder
// unit over the 16-bit draw, then one RAM read. Reset clears the pair count and
// the control state; the RAM is never cleared. A stalled response waits in the
// output register, and the next request may be taken and worked on meanwhile.
module dense_keyed_table_with_random_pick_top import dktr_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dktr_req_if.sink   req_i,
  dktr_rsp_if.source rsp_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = KEY_BITS + VALUE_BITS;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_RM_RD = 7'b0000100,
    S_RM_WR = 7'b0001000,
    S_MOD   = 7'b0010000,
    S_PICK  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e                state_q, state_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         issue_q, issue_d;
  logic                  pend_q, pend_d;
  logic [AW-1:0]         cmp_q, cmp_d;
  logic [AW-1:0]         slot_q, slot_d;
  kind_t                 kind_q, kind_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [VALUE_BITS-1:0] value_q, value_d;
  status_e               res_status_q, res_status_d;
  logic                  res_present_q, res_present_d;
  logic [KEY_BITS-1:0]   res_key_q, res_key_d;
  logic [VALUE_BITS-1:0] res_value_q, res_value_d;

  logic                  out_valid_q, out_valid_d;
  status_e               out_status_q, out_status_d;
  logic                  out_present_q, out_present_d;
  logic [FIELD_BITS-1:0] out_key_q, out_key_d;
  logic [FIELD_BITS-1:0] out_value_q, out_value_d;
  logic [TOTAL_BITS-1:0] out_total_q, out_total_d;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [EW-1:0]         ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [EW-1:0]         ram_rdata;
  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_value;

  logic                  mod_start;
  logic                  mod_done;
  logic [CW-1:0]         mod_rem;

  logic [63:0]           key_wide;
  logic [63:0]           value_wide;
  logic [63:0]           okey_wide;
  logic [63:0]           oval_wide;
  logic [63:0]           total_wide;
  logic [CW-1:0]         last_slot;
  logic                  match;

  assign key_wide   = {32'd0, req_i.req_key};
  assign value_wide = {32'd0, req_i.req_value};
  assign okey_wide  = 64'(res_key_q);
  assign oval_wide  = 64'(res_value_q);
  assign total_wide = 64'(count_q);
  assign last_slot  = count_q - CW'(1);
  assign rd_key     = ram_rdata[EW-1:VALUE_BITS];
  assign rd_value   = ram_rdata[VALUE_BITS-1:0];
  assign match      = (rd_key == key_q);

  assign req_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    issue_d       = issue_q;
    pend_d        = pend_q;
    cmp_d         = cmp_q;
    slot_d        = slot_q;
    kind_d        = kind_q;
    key_d         = key_q;
    value_d       = value_q;
    res_status_d  = res_status_q;
    res_present_d = res_present_q;
    res_key_d     = res_key_q;
    res_value_d   = res_value_q;
    out_valid_d   = out_valid_q;
    out_status_d  = out_status_q;
    out_present_d = out_present_q;
    out_key_d     = out_key_q;
    out_value_d   = out_value_q;
    out_total_d   = out_total_q;
    ram_we        = 1'b0;
    ram_waddr     = slot_q;
    ram_wdata     = {key_q, value_q};
    ram_raddr     = issue_q[AW-1:0];
    mod_start     = 1'b0;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          kind_d        = req_i.kind;
          key_d         = key_wide[KEY_BITS-1:0];
          value_d       = value_wide[VALUE_BITS-1:0];
          res_status_d  = ST_OK;
          res_present_d = 1'b0;
          res_key_d     = '0;
          res_value_d   = '0;
          issue_d       = '0;
          pend_d        = 1'b0;
          unique case (req_i.kind)
            KIND_PUT, KIND_GET, KIND_CONTAINS, KIND_REMOVE: begin
              state_d = S_SCAN;
            end
            KIND_PICK: begin
              if (count_q == '0) begin
                res_status_d = ST_EMPTY;
                state_d      = S_DONE;
              end else begin
                mod_start = 1'b1;
                state_d   = S_MOD;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        // Reads are issued one slot ahead of the compare.
        if (pend_q && match) begin
          res_present_d = 1'b1;
          slot_d        = cmp_q;
          state_d       = S_DONE;
          unique case (kind_q)
            KIND_PUT: begin
              ram_we    = 1'b1;
              ram_waddr = cmp_q;
            end
            KIND_GET: begin
              res_value_d = rd_value;
            end
            KIND_REMOVE: begin
              state_d = S_RM_RD;
            end
            default: begin
            end
          endcase
        end else if (issue_q == count_q) begin
          state_d = S_DONE;
          unique case (kind_q)
            KIND_PUT: begin
              if (count_q != CW'(CAPACITY)) begin
                ram_we    = 1'b1;
                ram_waddr = count_q[AW-1:0];
                count_d   = count_q + CW'(1);
              end else begin
                res_status_d = ST_FULL;
              end
            end
            KIND_GET, KIND_REMOVE: begin
              res_status_d = ST_NOT_FOUND;
            end
            default: begin
            end
          endcase
        end else begin
          ram_raddr = issue_q[AW-1:0];
          issue_d   = issue_q + CW'(1);
          pend_d    = 1'b1;
          cmp_d     = issue_q[AW-1:0];
        end
      end
      S_RM_RD: begin
        ram_raddr = last_slot[AW-1:0];
        state_d   = S_RM_WR;
      end
      S_RM_WR: begin
        // The last pair fills the freed slot; a no-op when they coincide.
        ram_we    = 1'b1;
        ram_waddr = slot_q;
        ram_wdata = ram_rdata;
        count_d   = last_slot;
        state_d   = S_DONE;
      end
      S_MOD: begin
        if (mod_done) begin
          ram_raddr = mod_rem[AW-1:0];
          state_d   = S_PICK;
        end
      end
      S_PICK: begin
        res_key_d = rd_key;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d   = 1'b1;
          out_status_d  = res_status_q;
          out_present_d = res_present_q;
          out_key_d     = okey_wide[FIELD_BITS-1:0];
          out_value_d   = oval_wide[FIELD_BITS-1:0];
          out_total_d   = total_wide[TOTAL_BITS-1:0];
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      issue_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      issue_q     <= issue_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_q         <= cmp_d;
    slot_q        <= slot_d;
    kind_q        <= kind_d;
    key_q         <= key_d;
    value_q       <= value_d;
    res_status_q  <= res_status_d;
    res_present_q <= res_present_d;
    res_key_q     <= res_key_d;
    res_value_q   <= res_value_d;
    out_status_q  <= out_status_d;
    out_present_q <= out_present_d;
    out_key_q     <= out_key_d;
    out_value_q   <= out_value_d;
    out_total_q   <= out_total_d;
  end

  dktr_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_pair_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  dktr_mod #(
    .CW (CW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (req_i.random_draw),
    .divisor_i  (count_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.present     = out_present_q;
  assign rsp_o.out_key     = out_key_q;
  assign rsp_o.out_value   = out_value_q;
  assign rsp_o.entry_total = out_total_q;

endmodule
